### hw/rtl/vvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vvp_pkg;

    // Pan mode codes; any other code acts as swapped stereo.
    localparam logic [1:0] PAN_MONO   = 2'd0;
    localparam logic [1:0] PAN_NORMAL = 2'd1;
    localparam logic [1:0] PAN_SWAP   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAN_MODE   = 2'd0;
    localparam logic [1:0] CFG_SFX_MASTER = 2'd1;
    localparam logic [1:0] CFG_MUS_MASTER = 2'd2;

    // Register reset values.
    localparam logic [1:0] PAN_MODE_RST = PAN_MONO;
    localparam logic [6:0] MASTER_RST   = 7'h7F;

    // Arithmetic constants.
    localparam int unsigned VOL_SHIFT  = 21;
    localparam logic [7:0]  PAN_CENTER = 8'h40;
    localparam logic [6:0]  PAN_MAX    = 7'h7F;
    localparam logic [7:0]  PAN_SPAN   = 8'h80;
    localparam logic [7:0]  MONO_GAIN  = 8'd64;
    localparam logic [23:0] BEND_ROUND = 24'd32;

    // Load enables for the three pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

`default_nettype wire

### hw/rtl/vvp_vol_pan.sv
`timescale 1ns / 1ps
`default_nettype none

module vvp_vol_pan (
    input  wire logic                i_clk,
    input  wire vvp_pkg::t_pipe_ctl  i_ctl,
    input  wire logic [1:0]          i_pan_mode,
    input  wire logic [6:0]          i_sfx_master,
    input  wire logic [6:0]          i_mus_master,
    input  wire logic [6:0]          i_velocity,
    input  wire logic [6:0]          i_patch_volume,
    input  wire logic [6:0]          i_track_volume,
    input  wire logic                i_is_sfx,
    input  wire logic [6:0]          i_track_pan,
    input  wire logic [6:0]          i_patch_pan,
    output logic      [13:0]         o_left_volume,
    output logic      [13:0]         o_right_volume
);

    // Stage 1 registers.
    logic [13:0] r_vel_patch;
    logic [13:0] r_track_master;
    logic [6:0]  r_pan;
    logic [1:0]  r_mode;
    // Stage 2 registers.
    logic [6:0]  r_vol;
    logic [7:0]  r_gain_l;
    logic [7:0]  r_gain_r;

    logic [6:0]  n_master;
    logic [7:0]  n_sum;
    logic [7:0]  n_off;
    logic [6:0]  n_pan;
    logic [27:0] n_prod;
    logic [7:0]  n_gain_lo;
    logic [7:0]  n_gain_hi;

    // Pick the master volume and clamp the combined pan.
    always_comb begin
        n_master = i_is_sfx ? i_sfx_master : i_mus_master;
        n_sum    = {1'b0, i_track_pan} + {1'b0, i_patch_pan};
        n_off    = n_sum - vvp_pkg::PAN_CENTER;
        if (n_sum < vvp_pkg::PAN_CENTER) begin
            n_pan = 7'd0;
        end else if (n_off > {1'b0, vvp_pkg::PAN_MAX}) begin
            n_pan = vvp_pkg::PAN_MAX;
        end else begin
            n_pan = n_off[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_vel_patch    <= i_velocity * i_patch_volume;
            r_track_master <= i_track_volume * n_master;
            r_pan          <= n_pan;
            r_mode         <= i_pan_mode;
        end
    end

    // Full product gives the base volume; the pan mode selects each side's gain.
    always_comb begin
        n_prod    = r_vel_patch * r_track_master;
        n_gain_lo = vvp_pkg::PAN_SPAN - {1'b0, r_pan};
        n_gain_hi = {1'b0, r_pan} + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_vol <= n_prod[27:vvp_pkg::VOL_SHIFT];
            case (r_mode)
                vvp_pkg::PAN_MONO: begin
                    r_gain_l <= vvp_pkg::MONO_GAIN;
                    r_gain_r <= vvp_pkg::MONO_GAIN;
                end
                vvp_pkg::PAN_NORMAL: begin
                    r_gain_l <= n_gain_lo;
                    r_gain_r <= n_gain_hi;
                end
                default: begin
                    r_gain_l <= n_gain_hi;
                    r_gain_r <= n_gain_lo;
                end
            endcase
        end
    end

    // Stage 3: side volumes, held as the output word.
    logic [14:0] n_left;
    logic [14:0] n_right;

    always_comb begin
        n_left  = r_vol * r_gain_l;
        n_right = r_vol * r_gain_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            o_left_volume  <= n_left[13:0];
            o_right_volume <= n_right[13:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/vvp_pitch.sv
`timescale 1ns / 1ps
`default_nettype none

module vvp_pitch (
    input  wire logic                i_clk,
    input  wire vvp_pkg::t_pipe_ctl  i_ctl,
    input  wire logic [15:0]         i_bend,
    input  wire logic [7:0]          i_step_down,
    input  wire logic [7:0]          i_step_up,
    input  wire logic [6:0]          i_key,
    output logic      [15:0]         o_pitch_word
);

    // Stage 1 registers.
    logic [16:0] r_mag;
    logic [7:0]  r_step;
    logic        r_neg1;
    logic        r_zero1;
    logic [6:0]  r_key1;
    // Stage 2 registers.
    logic [23:0] r_t;
    logic        r_neg2;
    logic        r_zero2;
    logic [6:0]  r_key2;

    // Bend magnitude and the step that goes with its direction.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            if (i_bend[15]) begin
                r_mag  <= 17'h10000 - {1'b0, i_bend};
                r_step <= i_step_down;
            end else begin
                r_mag  <= {1'b0, i_bend};
                r_step <= i_step_up;
            end
            r_neg1  <= i_bend[15];
            r_zero1 <= (i_bend == 16'd0);
            r_key1  <= i_key;
        end
    end

    // Scaled bend with rounding offset; at most 32768 * 255 + 32.
    logic [24:0] n_scaled;

    always_comb begin
        n_scaled = r_mag * r_step;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_t     <= n_scaled[23:0] + vvp_pkg::BEND_ROUND;
            r_neg2  <= r_neg1;
            r_zero2 <= r_zero1;
            r_key2  <= r_key1;
        end
    end

    // Stage 3: split into whole keys and fraction, then assemble the word.
    logic [10:0] n_whole;
    logic [7:0]  n_hi;
    logic [6:0]  n_frac;

    always_comb begin
        n_whole = {r_t[23:13]};
        if (r_zero2) begin
            n_hi   = {1'b0, r_key2};
            n_frac = 7'd0;
        end else if (r_neg2) begin
            n_hi   = 8'({1'b0, r_key2} - n_whole[7:0] - 8'd1);
            n_frac = 7'(7'd0 - r_t[12:6]);
        end else begin
            n_hi   = 8'({1'b0, r_key2} + n_whole[7:0]);
            n_frac = r_t[12:6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            o_pitch_word <= {n_hi, 1'b0, n_frac};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/voice_volume_pan_pitch_core.sv
// Voice volume, pan and pitch core. Each note event word yields one result word
// holding the left and right volumes and the 16-bit pitch word. The core is a
// three-stage pipeline: an event is taken every cycle while o_stall is low, and
// its result moves through the stage 1 and stage 2 registers into the output
// register. The stages follow the multiply chain (three multiplies for the
// base volume, one per side for the pan gain, one for the bend scale), each
// followed by a register.
// The last stage is the output register, so stalls from the output side
// back up through the stages and only reach o_stall once all three are full.
// Configuration (pan mode, sound-effect and music master volumes) is written
// through its own valid/ready port, which is always ready; write it only while
// no event is in flight.
`timescale 1ns / 1ps
`default_nettype none

module voice_volume_pan_pitch_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    // Event input channel.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [6:0]  i_velocity,
    input  wire logic [6:0]  i_patch_volume,
    input  wire logic [6:0]  i_track_volume,
    input  wire logic        i_is_sfx,
    input  wire logic [6:0]  i_track_pan,
    input  wire logic [6:0]  i_patch_pan,
    input  wire logic [15:0] i_bend,
    input  wire logic [7:0]  i_step_down,
    input  wire logic [7:0]  i_step_up,
    input  wire logic [6:0]  i_key,
    // Result output channel.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [13:0] o_left_volume,
    output logic      [13:0] o_right_volume,
    output logic      [15:0] o_pitch_word
);

    logic [1:0] r_pan_mode;
    logic [6:0] r_sfx_master;
    logic [6:0] r_mus_master;
    logic       cfg_we;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_mode   <= vvp_pkg::PAN_MODE_RST;
            r_sfx_master <= vvp_pkg::MASTER_RST;
            r_mus_master <= vvp_pkg::MASTER_RST;
        end else if (cfg_we) begin
            case (i_cfg_index)
                vvp_pkg::CFG_PAN_MODE:   r_pan_mode   <= i_cfg_data[1:0];
                vvp_pkg::CFG_SFX_MASTER: r_sfx_master <= i_cfg_data;
                vvp_pkg::CFG_MUS_MASTER: r_mus_master <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline occupancy; a stage loads when it is empty or its word moves on.
    logic [2:0]         r_vld;
    vvp_pkg::t_pipe_ctl ctl;

    always_comb begin
        ctl.ld3 = !r_vld[2] || !i_stall;
        ctl.ld2 = !r_vld[1] || ctl.ld3;
        ctl.ld1 = !r_vld[0] || ctl.ld2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'b000;
        end else begin
            if (ctl.ld1) begin
                r_vld[0] <= i_valid;
            end
            if (ctl.ld2) begin
                r_vld[1] <= r_vld[0];
            end
            if (ctl.ld3) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    assign o_stall = !ctl.ld1;
    assign o_valid = r_vld[2];

    // Volume and pan datapath.
    vvp_vol_pan u_vol_pan (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_pan_mode     (r_pan_mode),
        .i_sfx_master   (r_sfx_master),
        .i_mus_master   (r_mus_master),
        .i_velocity     (i_velocity),
        .i_patch_volume (i_patch_volume),
        .i_track_volume (i_track_volume),
        .i_is_sfx       (i_is_sfx),
        .i_track_pan    (i_track_pan),
        .i_patch_pan    (i_patch_pan),
        .o_left_volume  (o_left_volume),
        .o_right_volume (o_right_volume)
    );

    // Pitch datapath.
    vvp_pitch u_pitch (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_bend       (i_bend),
        .i_step_down  (i_step_down),
        .i_step_up    (i_step_up),
        .i_key        (i_key),
        .o_pitch_word (o_pitch_word)
    );

    // The input side is held off only when every stage holds a word.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == 3'b111))
        else $error("input stalled while a pipeline stage was empty");

    // Words in flight change only by what was accepted and delivered.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(r_vld) == $countones($past(r_vld))
            + ($past(i_valid && !o_stall) ? 1 : 0)
            - ($past(o_valid && !i_stall) ? 1 : 0)))
        else $error("pipeline lost or invented a word");

    // A pan mode write lands in the register.
    a_cfg_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_we && (i_cfg_index == vvp_pkg::CFG_PAN_MODE))
        |=> (r_pan_mode == $past(i_cfg_data[1:0])))
        else $error("pan mode write not taken");

endmodule

`default_nettype wire

### sim/voice_volume_pan_pitch_core_test.sv
`timescale 1ns / 1ps

module voice_volume_pan_pitch_core_test;

    // Pan mode code that the core treats like swapped stereo.
    localparam logic [1:0] PAN_UNUSED = 2'd3;
    localparam int PIPE_DEPTH   = 3;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic [6:0]  velocity;
        logic [6:0]  patch_volume;
        logic [6:0]  track_volume;
        logic        is_sfx;
        logic [6:0]  track_pan;
        logic [6:0]  patch_pan;
        logic [15:0] bend;
        logic [7:0]  step_down;
        logic [7:0]  step_up;
        logic [6:0]  key;
    } t_note;

    typedef struct packed {
        logic [13:0] left;
        logic [13:0] right;
        logic [15:0] pitch;
    } t_voice;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [6:0]  i_velocity;
    logic [6:0]  i_patch_volume;
    logic [6:0]  i_track_volume;
    logic        i_is_sfx;
    logic [6:0]  i_track_pan;
    logic [6:0]  i_patch_pan;
    logic [15:0] i_bend;
    logic [7:0]  i_step_down;
    logic [7:0]  i_step_up;
    logic [6:0]  i_key;
    logic        o_valid;
    logic        i_stall;
    logic [13:0] o_left_volume;
    logic [13:0] o_right_volume;
    logic [15:0] o_pitch_word;

    // Shadow copy of the configuration registers.
    logic [1:0]  pan_mode_q;
    logic [6:0]  sfx_master_q;
    logic [6:0]  music_master_q;

    t_voice      expected_voices[$];
    int unsigned failures = 0;
    int unsigned reported = 0;

    // Random idling controls and the long output hold-off request.
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;

    voice_volume_pan_pitch_core dut (.*);

    always #1 i_clk = ~i_clk;

    // Volume, pan and pitch word of one note under the current settings.
    function automatic t_voice predict_voice(input t_note n);
        t_voice      v;
        logic [31:0] master;
        logic [31:0] vol;
        logic [31:0] sum;
        logic [31:0] pan;
        logic [31:0] bend;
        logic [31:0] mag;
        logic [31:0] t;
        logic [31:0] whole;
        logic [31:0] frac;
        logic [31:0] key;
        logic [31:0] pw;
        logic [31:0] left;
        logic [31:0] right;

        master = n.is_sfx ? {25'd0, sfx_master_q} : {25'd0, music_master_q};
        vol = {25'd0, n.velocity} * {25'd0, n.patch_volume} * {25'd0, n.track_volume};
        vol = (vol * master) >> vvp_pkg::VOL_SHIFT;

        if (pan_mode_q == vvp_pkg::PAN_MONO) begin
            left  = vol * vvp_pkg::MONO_GAIN;
            right = vol * vvp_pkg::MONO_GAIN;
        end else begin
            sum = {25'd0, n.track_pan} + {25'd0, n.patch_pan};
            if (sum < vvp_pkg::PAN_CENTER)
                pan = 0;
            else if (sum - vvp_pkg::PAN_CENTER > vvp_pkg::PAN_MAX)
                pan = vvp_pkg::PAN_MAX;
            else
                pan = sum - vvp_pkg::PAN_CENTER;
            // Normal stereo puts the wide gain on the left; everything else swaps.
            if (pan_mode_q == vvp_pkg::PAN_NORMAL) begin
                left  = vol * (vvp_pkg::PAN_SPAN - pan);
                right = vol * (pan + 1);
            end else begin
                right = vol * (vvp_pkg::PAN_SPAN - pan);
                left  = vol * (pan + 1);
            end
        end

        // Bend moves the key by whole steps and a 7-bit fraction.
        key  = {25'd0, n.key};
        bend = {16'd0, n.bend};
        if (bend == 0) begin
            pw = key << 8;
        end else if (bend[15]) begin
            mag   = 32'h10000 - bend;
            t     = vvp_pkg::BEND_ROUND + mag * {24'd0, n.step_down};
            whole = (t >> 13) + 1;
            frac  = (vvp_pkg::PAN_SPAN - ((t & 32'h1FFF) >> 6)) & 32'h7F;
            pw    = ((key - whole) << 8) | frac;
        end else begin
            t     = vvp_pkg::BEND_ROUND + bend * {24'd0, n.step_up};
            whole = t >> 13;
            frac  = (t & 32'h1FFF) >> 6;
            pw    = ((key + whole) << 8) | frac;
        end

        v.left  = left[13:0];
        v.right = right[13:0];
        v.pitch = pw[15:0];
        return v;
    endfunction

    // Hand-picked notes: field extremes, pan clamp edges and bend corners.
    function automatic t_note directed_note(input int idx);
        t_note n;
        case (idx)
            0:  n = {7'd0, 7'd0, 7'd0, 1'b0, 7'd0, 7'd0, 16'h0000, 8'd0, 8'd0, 7'd0};
            1:  n = {7'd127, 7'd127, 7'd127, 1'b1, 7'd127, 7'd127, 16'h7FFF,
                     8'd255, 8'd255, 7'd127};
            2:  n = {7'd127, 7'd127, 7'd127, 1'b0, 7'd64, 7'd64, 16'h0000,
                     8'd255, 8'd255, 7'd60};
            3:  n = {7'd127, 7'd100, 7'd90, 1'b0, 7'd0, 7'd0, 16'h8000,
                     8'd255, 8'd0, 7'd0};
            4:  n = {7'd100, 7'd127, 7'd127, 1'b1, 7'd0, 7'd64, 16'hFFFF,
                     8'd1, 8'd200, 7'd64};
            5:  n = {7'd127, 7'd127, 7'd80, 1'b0, 7'd127, 7'd64, 16'h0001,
                     8'd200, 8'd1, 7'd100};
            6:  n = {7'd90, 7'd127, 7'd127, 1'b1, 7'd127, 7'd127, 16'h7FFF,
                     8'd0, 8'd255, 7'd127};
            7:  n = {7'd127, 7'd127, 7'd127, 1'b0, 7'd63, 7'd0, 16'h8000,
                     8'd0, 8'd255, 7'd5};
            8:  n = {7'd1, 7'd1, 7'd1, 1'b1, 7'd30, 7'd100, 16'h0100,
                     8'd7, 8'd128, 7'd40};
            9:  n = {7'd127, 7'd127, 7'd127, 1'b0, 7'd65, 7'd127, 16'hE000,
                     8'd3, 8'd9, 7'd70};
            10: n = {7'd127, 7'd127, 7'd1, 1'b1, 7'd10, 7'd90, 16'h00FF,
                     8'd64, 8'd32, 7'd20};
            default:
                n = {7'h55, 7'h2A, 7'h55, 1'b1, 7'h2A, 7'h55, 16'h5555,
                     8'hAA, 8'h55, 7'h2A};
        endcase
        return n;
    endfunction

    // Random note with bend weighted toward zero, small values and corners.
    function automatic t_note random_note();
        t_note       n;
        int unsigned pick;

        n.velocity     = ($urandom_range(0, 3) == 0) ? 7'd127 : 7'($urandom_range(0, 127));
        n.patch_volume = 7'($urandom_range(0, 127));
        n.track_volume = 7'($urandom_range(0, 127));
        n.is_sfx       = 1'($urandom_range(0, 1));
        n.track_pan    = 7'($urandom_range(0, 127));
        n.patch_pan    = 7'($urandom_range(0, 127));
        n.step_down    = 8'($urandom_range(0, 255));
        n.step_up      = 8'($urandom_range(0, 255));
        n.key          = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 7);
        case (pick)
            0: n.bend = 16'h0000;
            1: begin
                n.bend = 16'($urandom_range(1, 300));
                if ($urandom_range(0, 1) == 1)
                    n.bend = -n.bend;
            end
            2: n.bend = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
            default: n.bend = 16'($urandom);
        endcase
        return n;
    endfunction

    // Offer one note and record its expected voice once it is taken.
    task automatic send_note(input t_note n);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_velocity     <= n.velocity;
        i_patch_volume <= n.patch_volume;
        i_track_volume <= n.track_volume;
        i_is_sfx       <= n.is_sfx;
        i_track_pan    <= n.track_pan;
        i_patch_pan    <= n.patch_pan;
        i_bend         <= n.bend;
        i_step_down    <= n.step_down;
        i_step_up      <= n.step_up;
        i_key          <= n.key;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        expected_voices.push_back(predict_voice(n));
    endtask

    // Stop offering notes and wait for every expected voice to come out.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_voices.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            vvp_pkg::CFG_PAN_MODE:   pan_mode_q     = data[1:0];
            vvp_pkg::CFG_SFX_MASTER: sfx_master_q   = data;
            vvp_pkg::CFG_MUS_MASTER: music_master_q = data;
            default: ;
        endcase
    endtask

    // Write all three registers; the pan mode word carries random upper bits.
    task automatic configure(input logic [1:0] mode, input logic [6:0] sfx,
                             input logic [6:0] music);
        logic [4:0] pad;
        pad = 5'($urandom_range(0, 31));
        write_reg(vvp_pkg::CFG_PAN_MODE, {pad, mode});
        write_reg(vvp_pkg::CFG_SFX_MASTER, sfx);
        write_reg(vvp_pkg::CFG_MUS_MASTER, music);
        i_cfg_valid <= 1'b0;
    endtask

    // Directed notes under the reset settings: mono, both masters full.
    task automatic test_reset_defaults();
        for (int i = 0; i < 12; i++)
            send_note(directed_note(i));
        wait_idle();
    endtask

    // The same notes in normal stereo with the sound-effect master muted.
    task automatic test_directed_stereo();
        configure(vvp_pkg::PAN_NORMAL, 7'd0, 7'd127);
        for (int i = 0; i < 12; i++)
            send_note(directed_note(i));
        wait_idle();
    endtask

    // Random notes across every pan mode and a spread of master volumes.
    task automatic test_config_sweep();
        logic [1:0] mode;
        logic [6:0] sfx;
        logic [6:0] music;
        for (int phase = 0; phase < 8; phase++) begin
            mode = phase[1:0];
            case (phase)
                0: begin sfx = 7'd127; music = 7'd0;   end
                1: begin sfx = 7'd0;   music = 7'd127; end
                2: begin sfx = 7'd127; music = 7'd127; end
                default: begin
                    sfx   = 7'($urandom_range(0, 127));
                    music = 7'($urandom_range(0, 127));
                end
            endcase
            configure(mode, sfx, music);
            repeat (40) send_note(random_note());
            wait_idle();
        end
    endtask

    // Hold the output off long enough that the pipeline fills and stalls input.
    task automatic test_backpressure();
        configure(vvp_pkg::PAN_SWAP, 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_note(random_note());
        wait_idle();
    endtask

    // Back-to-back notes with no idling on either side.
    task automatic test_full_rate();
        configure(PAN_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (20) send_note(random_note());
        wait_idle();
        configure(vvp_pkg::PAN_NORMAL, 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
        repeat (20) send_note(random_note());
        wait_idle();
    endtask

    // Output stall: a counted long hold on request, otherwise random bursts.
    initial begin : output_stall_gen
        int unsigned hold_left;
        int unsigned burst_left;
        logic        stall_next;
        hold_left  = 0;
        burst_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                stall_next = 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 13);
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            i_stall <= stall_next;
        end
    end

    // Compare each taken voice word against the oldest expectation.
    always @(negedge i_clk) begin : voice_check
        t_voice want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_voices.size() == 0) begin
                failures++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected voice: left=%0d right=%0d pitch=%04h",
                             o_left_volume, o_right_volume, o_pitch_word);
                end
            end else begin
                want = expected_voices.pop_front();
                if (want.left != o_left_volume || want.right != o_right_volume ||
                    want.pitch != o_pitch_word) begin
                    failures++;
                    if (reported < MAX_REPORTS) begin
                        reported++;
                        $display("voice mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                 want.left, o_left_volume, want.right, o_right_volume);
                        $display("                pitch exp %04h got %04h",
                                 want.pitch, o_pitch_word);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= vvp_pkg::CFG_PAN_MODE;
        i_cfg_data     <= 7'd0;
        i_valid        <= 1'b0;
        i_velocity     <= 7'd0;
        i_patch_volume <= 7'd0;
        i_track_volume <= 7'd0;
        i_is_sfx       <= 1'b0;
        i_track_pan    <= 7'd0;
        i_patch_pan    <= 7'd0;
        i_bend         <= 16'd0;
        i_step_down    <= 8'd0;
        i_step_up      <= 8'd0;
        i_key          <= 7'd0;
        pan_mode_q     = vvp_pkg::PAN_MODE_RST;
        sfx_master_q   = vvp_pkg::MASTER_RST;
        music_master_q = vvp_pkg::MASTER_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_stereo();
        test_config_sweep();
        test_backpressure();
        test_full_rate();

        if (failures == 0 && expected_voices.size() == 0)
            $display("[voice_volume_pan_pitch_core] OK");
        else
            $display("[voice_volume_pan_pitch_core] ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #1000000;
        $display("[voice_volume_pan_pitch_core] ERROR");
        $finish;
    end

endmodule
